// File: design/es2c_pkg.sv
// Shared types, constants and the month-length table for the epoch-to-calendar converter.
`default_nettype none

package es2c_pkg;

   localparam int unsigned ACC_W  = 31;
   localparam int unsigned DAYS_W = 15;
   localparam int unsigned STEP_W = 4;

   localparam logic [ACC_W-1:0] SECS_PER_DAY  = 31'd86400;
   localparam logic [ACC_W-1:0] SECS_PER_HOUR = 31'd3600;
   localparam logic [ACC_W-1:0] SECS_PER_MIN  = 31'd60;
   localparam logic [ACC_W-1:0] DAYS_PER_WEEK = 31'd7;
   localparam logic [ACC_W-1:0] LEAP_YEAR_LEN = 31'd366;
   localparam logic [ACC_W-1:0] NORM_YEAR_LEN = 31'd365;

   localparam logic [STEP_W-1:0] DAY_TOP  = 4'd14;
   localparam logic [STEP_W-1:0] HOUR_TOP = 4'd4;
   localparam logic [STEP_W-1:0] MIN_TOP  = 4'd5;
   localparam logic [STEP_W-1:0] WDAY_TOP = 4'd11;

   localparam logic [7:0] EPOCH_YEARS   = 8'd70;
   localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
   localparam logic [3:0] FEB_INDEX     = 4'd1;
   localparam logic [3:0] LAST_MONTH    = 4'd11;

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic idle;
      logic done;
   } es2c_status_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [8:0] day_of_year;
      logic [7:0] years_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
   } es2c_result_type;

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      if (mon > LAST_MONTH) begin
         len = 5'd31;
      end else if (mon == FEB_INDEX) begin
         len = leap ? 5'd29 : 5'd28;
      end else begin
         len = MONTH_LEN[mon];
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// File: design/es2c_ifs.sv
// Request and response channel interfaces of the epoch-to-calendar converter.
`default_nettype none

interface es2c_req_if;
   logic        valid;
   logic        ready;
   logic [30:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2c_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] second;
   logic [5:0] minute;
   logic [4:0] hour;
   logic [2:0] weekday;
   logic [8:0] day_of_year;
   logic [7:0] years_since_1900;
   logic [3:0] month_index;
   logic [4:0] day_of_month;

   modport source (output valid, output second, output minute, output hour, output weekday,
                   output day_of_year, output years_since_1900, output month_index,
                   output day_of_month, input ready);
   modport sink   (input valid, input second, input minute, input hour, input weekday,
                   input day_of_year, input years_since_1900, input month_index,
                   input day_of_month, output ready);
endinterface

`default_nettype wire

// File: design/es2c_csub.sv
// Shared compare-and-subtract unit used by every step of the converter.
`default_nettype none

module es2c_csub (
   input  wire logic [es2c_pkg::ACC_W-1:0] a_value,
   input  wire logic [es2c_pkg::ACC_W-1:0] b_value,
   output logic                            ge,
   output logic [es2c_pkg::ACC_W-1:0]      diff
);
   import es2c_pkg::*;

   logic [ACC_W:0] wide_diff;

   assign wide_diff = {1'b0, a_value} - {1'b0, b_value};
   assign ge        = ~wide_diff[ACC_W];
   assign diff      = wide_diff[ACC_W-1:0];

endmodule

`default_nettype wire

// File: design/es2c_core.sv
// Sequencer and working registers that drive the shared compare-subtract unit.
`default_nettype none

module es2c_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [30:0]              epoch_seconds,
   input  wire logic                     out_free,
   output es2c_pkg::es2c_status_type     status,
   output es2c_pkg::es2c_result_type     result
);
   import es2c_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_DAY  = 8'b0000_0010,
      ST_HOUR = 8'b0000_0100,
      ST_MIN  = 8'b0000_1000,
      ST_WDAY = 8'b0001_0000,
      ST_YEAR = 8'b0010_0000,
      ST_MON  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DAYS_W-1:0]  days_ff, days_in;
   logic [4:0]         hour_ff, hour_in;
   logic [5:0]         minute_ff, minute_in;
   logic [5:0]         second_ff, second_in;
   logic [2:0]         weekday_ff, weekday_in;
   logic [7:0]         year_ff, year_in;
   logic [8:0]         yday_ff, yday_in;
   logic [3:0]         mon_ff, mon_in;
   logic [4:0]         dom_ff, dom_in;

   logic [ACC_W-1:0]   op_b;
   logic [ACC_W-1:0]   sub_diff;
   logic [ACC_W-1:0]   rem_next;
   logic               sub_ge;
   logic               leap;

   es2c_csub u_csub (
      .a_value (acc_ff),
      .b_value (op_b),
      .ge      (sub_ge),
      .diff    (sub_diff)
   );

   assign leap     = (year_ff[1:0] == 2'b00);
   assign rem_next = sub_ge ? sub_diff : acc_ff;

   always_comb begin
      case (state_ff)
         ST_DAY:  op_b = SECS_PER_DAY << step_ff;
         ST_HOUR: op_b = SECS_PER_HOUR << step_ff;
         ST_MIN:  op_b = SECS_PER_MIN << step_ff;
         ST_WDAY: op_b = DAYS_PER_WEEK << step_ff;
         ST_YEAR: op_b = leap ? LEAP_YEAR_LEN : NORM_YEAR_LEN;
         ST_MON:  op_b = ACC_W'(month_days(mon_ff, leap));
         default: op_b = '0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      step_in    = step_ff;
      days_in    = days_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      weekday_in = weekday_ff;
      year_in    = year_ff;
      yday_in    = yday_ff;
      mon_in     = mon_ff;
      dom_in     = dom_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               acc_in   = ACC_W'(epoch_seconds);
               step_in  = DAY_TOP;
               days_in  = '0;
               state_in = ST_DAY;
            end
         end
         ST_DAY: begin
            acc_in  = rem_next;
            days_in = days_ff | (DAYS_W'(sub_ge) << step_ff);
            if (step_ff == '0) begin
               step_in  = HOUR_TOP;
               hour_in  = '0;
               state_in = ST_HOUR;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_HOUR: begin
            acc_in  = rem_next;
            hour_in = hour_ff | (5'(sub_ge) << step_ff);
            if (step_ff == '0) begin
               step_in   = MIN_TOP;
               minute_in = '0;
               state_in  = ST_MIN;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_MIN: begin
            acc_in    = rem_next;
            minute_in = minute_ff | (6'(sub_ge) << step_ff);
            if (step_ff == '0) begin
               second_in = rem_next[5:0];
               acc_in    = ACC_W'(days_ff) + ACC_W'(EPOCH_WEEKDAY);
               step_in   = WDAY_TOP;
               state_in  = ST_WDAY;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_WDAY: begin
            acc_in = rem_next;
            if (step_ff == '0) begin
               weekday_in = rem_next[2:0];
               acc_in     = ACC_W'(days_ff);
               year_in    = EPOCH_YEARS;
               state_in   = ST_YEAR;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_YEAR: begin
            if (sub_ge) begin
               acc_in  = sub_diff;
               year_in = year_ff + 8'd1;
            end else begin
               yday_in  = acc_ff[8:0];
               mon_in   = '0;
               state_in = ST_MON;
            end
         end
         ST_MON: begin
            if (sub_ge && (mon_ff != LAST_MONTH)) begin
               acc_in = sub_diff;
               mon_in = mon_ff + 4'd1;
            end else begin
               dom_in   = acc_ff[4:0] + 5'd1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      step_ff    <= step_in;
      days_ff    <= days_in;
      hour_ff    <= hour_in;
      minute_ff  <= minute_in;
      second_ff  <= second_in;
      weekday_ff <= weekday_in;
      year_ff    <= year_in;
      yday_ff    <= yday_in;
      mon_ff     <= mon_in;
      dom_ff     <= dom_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   assign result.second           = second_ff;
   assign result.minute           = minute_ff;
   assign result.hour             = hour_ff;
   assign result.weekday          = weekday_ff;
   assign result.day_of_year      = yday_ff;
   assign result.years_since_1900 = year_ff;
   assign result.month_index      = mon_ff;
   assign result.day_of_month     = dom_ff;

endmodule

`default_nettype wire

// File: design/epoch_seconds_to_calendar_top.sv
// Top level of the epoch-to-calendar converter: request handshake, core and response register.
// Steps: days, hours, minutes and weekday bit by bit, then whole years (0..68) and whole
// months (0..11) one at a time; the result then moves to the response register.
// Flow: one request at a time; a new request is not taken until the last result has moved to
// the response register. The shared compare-subtract unit takes one step a cycle.
// Reset: synchronous, active high; clears the sequencer and the response valid flag.
`default_nettype none

module epoch_seconds_to_calendar_top (
   input  wire logic  clock,
   input  wire logic  reset,
   es2c_req_if.sink   req_chan,
   es2c_rsp_if.source rsp_chan
);
   import es2c_pkg::*;

   es2c_status_type core_status;
   es2c_result_type core_result;
   es2c_result_type rsp_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;
   logic            req_beat;

   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = core_status.idle;
   assign req_beat       = req_chan.valid & req_chan.ready;

   es2c_core u_core (
      .clock         (clock),
      .reset         (reset),
      .start         (req_beat),
      .epoch_seconds (req_chan.epoch_seconds),
      .out_free      (out_free),
      .status        (core_status),
      .result        (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_status.done && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_status.done && out_free) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.second           = rsp_data_ff.second;
   assign rsp_chan.minute           = rsp_data_ff.minute;
   assign rsp_chan.hour             = rsp_data_ff.hour;
   assign rsp_chan.weekday          = rsp_data_ff.weekday;
   assign rsp_chan.day_of_year      = rsp_data_ff.day_of_year;
   assign rsp_chan.years_since_1900 = rsp_data_ff.years_since_1900;
   assign rsp_chan.month_index      = rsp_data_ff.month_index;
   assign rsp_chan.day_of_month     = rsp_data_ff.day_of_month;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_chan.ready)
      else $error("request taken while a conversion is in flight");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (core_status.done && out_free) |=> rsp_valid_ff)
      else $error("finished conversion not moved to the response register");

   a_status_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(core_status.idle && core_status.done))
      else $error("core idle and done at once");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.month_index <= LAST_MONTH) &&
                       (rsp_data_ff.hour <= 5'd23) && (rsp_data_ff.weekday <= 3'd6) &&
                       (rsp_data_ff.day_of_month != 5'd0))
      else $error("response field out of range");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the epoch seconds to UTC calendar converter.
`timescale 1ns / 1ps

module testbench;
   import es2c_pkg::*;

   localparam int unsigned MAX_EPOCH   = 31'h7FFF_FFFF;
   localparam int unsigned DAY_SECS    = 86400;
   localparam int unsigned LAST_DAY    = MAX_EPOCH / DAY_SECS - 1;
   localparam int unsigned LONG_HOLD   = 600;
   localparam int unsigned SETTLE_CYC  = 150;
   localparam int unsigned REPORT_MAX  = 10;
   localparam int unsigned RANDOM_RUN  = 360;

   localparam int unsigned DAYS_IN_MONTH [12] = '{
      31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   es2c_req_if req_bus ();
   es2c_rsp_if rsp_bus ();

   epoch_seconds_to_calendar_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   es2c_result_type pending_dates[$];

   int unsigned send_idle_pct   = 0;
   int unsigned recv_idle_pct   = 0;
   int unsigned stalls_asked    = 0;
   int unsigned stalls_served   = 0;
   int unsigned hold_left       = 0;
   int unsigned stamps_sent     = 0;
   int unsigned directed_sent   = 0;
   int unsigned dates_checked   = 0;
   int unsigned field_errors    = 0;
   int unsigned stray_results   = 0;
   int unsigned failures        = 0;

   always #5 clock = ~clock;

   function automatic es2c_result_type calendar_from_epoch(input logic [30:0] stamp);
      es2c_result_type date;
      int unsigned     secs_today;
      int unsigned     days_left;
      int unsigned     year;
      int unsigned     year_days;
      int unsigned     month;
      int unsigned     month_days_now;
      secs_today  = int'(stamp) % DAY_SECS;
      days_left   = int'(stamp) / DAY_SECS;
      date.second  = 6'(secs_today % 60);
      date.minute  = 6'((secs_today / 60) % 60);
      date.hour    = 5'(secs_today / 3600);
      date.weekday = 3'((days_left + 4) % 7);
      year      = 1970;
      year_days = 365;
      while (days_left >= year_days) begin
         days_left -= year_days;
         year++;
         year_days = (year % 4 == 0) ? 366 : 365;
      end
      date.day_of_year      = 9'(days_left);
      date.years_since_1900 = 8'(year - 1900);
      month = 0;
      forever begin
         month_days_now = DAYS_IN_MONTH[month];
         if (month == 1) month_days_now = (year_days == 366) ? 29 : 28;
         if (days_left < month_days_now || month == 11) break;
         days_left -= month_days_now;
         month++;
      end
      date.month_index  = 4'(month);
      date.day_of_month = 5'(days_left + 1);
      return date;
   endfunction

   task automatic send_epoch(input logic [30:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.epoch_seconds <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_dates.push_back(calendar_from_epoch(stamp));
      stamps_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_dates();
      req_bus.valid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
   endtask

   function automatic logic [30:0] random_epoch();
      int unsigned pick;
      int unsigned day;
      pick = $urandom_range(99);
      day  = $urandom_range(LAST_DAY);
      if (pick < 45) return 31'($urandom);
      if (pick < 70) return 31'(day * DAY_SECS + ($urandom_range(1) ? DAY_SECS - 1 : 0));
      if (pick < 85) return 31'(day * DAY_SECS + $urandom_range(DAY_SECS - 1));
      if (pick < 95) return 31'($urandom_range(3 * 366 * DAY_SECS));
      return 31'(MAX_EPOCH - $urandom_range(400 * DAY_SECS));
   endfunction

   task automatic test_directed();
      logic [30:0] stamps [$];
      stamps = '{
         31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
         31'd2678399, 31'd2678400, 31'd5097599, 31'd5097600,
         31'd31535999, 31'd31536000, 31'd68169600, 31'd94608000, 31'd94694399,
         31'd946684799, 31'd951782400, 31'd978307199, 31'd983404800,
         31'h2AAA_AAAA, 31'h5555_5555, 31'h7FFF_FFFE, 31'h7FFF_FFFF
      };
      send_idle_pct = 30;
      recv_idle_pct = 75;
      foreach (stamps[i]) send_epoch(stamps[i]);
      directed_sent = stamps.size();
   endtask

   task automatic test_random(input int unsigned sender_pct, input int unsigned receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (RANDOM_RUN) send_epoch(random_epoch());
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stalls_asked++;
      repeat (8) send_epoch(random_epoch());
   endtask

   task automatic test_pause_until_empty();
      send_idle_pct = 0;
      recv_idle_pct = 30;
      repeat (4) send_epoch(random_epoch());
      wait_for_dates();
      repeat (4) send_epoch(random_epoch());
   endtask

   // hold ready low during a requested long stall, else toggle at random
   always @(negedge clock) begin
      if (stalls_served != stalls_asked) begin
         stalls_served = stalls_asked;
         hold_left     = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         if (failures < REPORT_MAX)
            $display("MISMATCH result %0d %s: expected %0d, got %0d",
                     dates_checked, name, want, got);
         field_errors++;
         failures++;
      end
   endtask

   always @(posedge clock) begin
      es2c_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_dates.size() == 0) begin
            if (failures < REPORT_MAX)
               $display("MISMATCH unexpected result beat at %0t", $realtime);
            stray_results++;
            failures++;
         end else begin
            want = pending_dates.pop_front();
            check_field("second", want.second, rsp_bus.second);
            check_field("minute", want.minute, rsp_bus.minute);
            check_field("hour", want.hour, rsp_bus.hour);
            check_field("weekday", want.weekday, rsp_bus.weekday);
            check_field("day_of_year", want.day_of_year, rsp_bus.day_of_year);
            check_field("years_since_1900", want.years_since_1900,
                        rsp_bus.years_since_1900);
            check_field("month_index", want.month_index, rsp_bus.month_index);
            check_field("day_of_month", want.day_of_month, rsp_bus.day_of_month);
            dates_checked++;
         end
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.epoch_seconds = '0;
      rsp_bus.ready         = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random(30, 75);
      test_backpressure();
      test_pause_until_empty();
      test_random(75, 30);
      test_random(0, 0);

      wait_for_dates();
      repeat (SETTLE_CYC) @(negedge clock);
      if (pending_dates.size() != 0) begin
         $display("MISMATCH %0d results never arrived", pending_dates.size());
         failures++;
      end

      $display("Converted %0d timestamps (%0d directed, rest random across 1970-2038).",
               stamps_sent, directed_sent);
      $display("Checked %0d calendar results: %0d field mismatches, %0d stray beats.",
               dates_checked, field_errors, stray_results);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout: %0d results still pending", pending_dates.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
design/es2c_pkg.sv
design/es2c_ifs.sv
design/es2c_csub.sv
design/es2c_core.sv
design/epoch_seconds_to_calendar_top.sv
sim/testbench.sv
